/* src/lcats_pkg.sv */
// ----------------------------------------------------------------------------
// lcats_pkg
// Widths, request codes and register indexes of the weighing front end.
// ----------------------------------------------------------------------------
package lcats_pkg;

   // window length, a power of two
   localparam int TAPS    = 128;
   localparam int TAPS_W  = $clog2(TAPS);

   localparam int BYTE_W   = 8;
   localparam int RAW_W    = 12;
   localparam int SUM_W    = RAW_W + TAPS_W;
   localparam int GAIN_W   = 18;
   localparam int PREC_W   = 8;
   localparam int GAIN_FRAC = 16;
   localparam int PROD_W   = SUM_W + GAIN_W;
   localparam int SHIFT    = TAPS_W + GAIN_FRAC;
   localparam int MAG_W    = PROD_W - SHIFT;
   localparam int CNT_W    = $clog2(MAG_W);
   localparam int WEIGHT_W = 16;
   localparam int WIDE_W   = (MAG_W + 2 > WEIGHT_W + 1) ? MAG_W + 2 : WEIGHT_W + 1;

   localparam int REQ_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(46199);
   localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(5);

   typedef enum logic [REQ_W-1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_TARE   = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN      = 2'd0,
      CSR_PRECISION = 2'd1,
      CSR_SPARE2    = 2'd2,
      CSR_SPARE3    = 2'd3
   } csr_index_type;

endpackage

/* src/load_cell_averaging_tare_scale.sv */
// ----------------------------------------------------------------------------
// load_cell_averaging_tare_scale
// Moving-average weighing front end with tare, ring of samples in one RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time. A sample is a RAM read, then sum update and
// write back; a tare is done on acceptance. A read takes the difference,
// multiplies by the gain, then runs a bit-serial remainder by the precision
// (one bit of the 14-bit magnitude a cycle; skipped with precision zero) and
// the final rounding, which waits while the previous result is still stalled.
// The block comes out of reset ready, with no clearing pass: ring entries
// not yet written read as zero until the write pointer first wraps.
module load_cell_averaging_tare_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lcats_pkg::REQ_W-1:0]        req_type,
   input  logic [lcats_pkg::BYTE_W-1:0]       req_adc_high_byte,
   input  logic [lcats_pkg::BYTE_W-1:0]       req_adc_low_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lcats_pkg::WEIGHT_W-1:0] rsp_weight,
   output logic                               rsp_auto_tared,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lcats_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcats_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lcats_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DIFF,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic signed [WIDE_W-1:0] W_MAX = WIDE_W'((1 << (WEIGHT_W - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] W_MIN = -W_MAX - WIDE_W'(1);

   state_type           state_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [PREC_W-1:0]   prec_ff;
   logic [TAPS_W-1:0]   wr_idx_ff;
   logic                wrapped_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    ref_ff;
   logic                tared_ff;
   logic                auto_ff;
   logic [RAW_W-1:0]    raw_ff;
   logic [RAW_W-1:0]    rd_data_ff;
   logic                neg_ff;
   logic [SUM_W-1:0]    absdiff_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic [MAG_W-1:0]    mag_sh_ff;
   logic [PREC_W-1:0]   rem_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic                auto_out_ff;

   logic [RAW_W-1:0]    ring [TAPS];

   logic                req_accept;
   logic                mem_we;
   logic [RAW_W-1:0]    raw_in;
   logic [RAW_W-1:0]    old_in;
   logic signed [SUM_W:0] diff_in;
   logic [PROD_W-1:0]   prod_in;
   logic [PREC_W:0]     trial_in;
   logic [PREC_W-1:0]   rem_in;
   logic [MAG_W:0]      adj_in;
   logic signed [WIDE_W-1:0] wide_in;
   logic signed [WEIGHT_W-1:0] weight_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = weight_ff;
   assign rsp_auto_tared = auto_out_ff;
   assign mem_we     = (state_ff == ST_SAMPLE);

   always_comb begin
      raw_in   = {req_adc_high_byte[4:0], req_adc_low_byte[7:1]};
      old_in   = wrapped_ff ? rd_data_ff : '0;
      diff_in  = $signed({1'b0, sum_ff}) - $signed({1'b0, ref_ff});
      prod_in  = PROD_W'(absdiff_ff) * PROD_W'(gain_ff);
      trial_in = {rem_ff, mag_sh_ff[MAG_W-1]};
      rem_in   = (trial_in >= {1'b0, prec_ff}) ? PREC_W'(trial_in - {1'b0, prec_ff})
                                               : trial_in[PREC_W-1:0];
      if (neg_ff) begin
         adj_in = {1'b0, mag_ff} - (MAG_W + 1)'(rem_ff);
      end else if (rem_ff != '0) begin
         adj_in = {1'b0, mag_ff} + (MAG_W + 1)'(prec_ff) - (MAG_W + 1)'(rem_ff);
      end else begin
         adj_in = {1'b0, mag_ff};
      end
      wide_in = neg_ff ? -$signed(WIDE_W'(adj_in)) : $signed(WIDE_W'(adj_in));
      if (wide_in > W_MAX) begin
         weight_in = W_MAX[WEIGHT_W-1:0];
      end else if (wide_in < W_MIN) begin
         weight_in = W_MIN[WEIGHT_W-1:0];
      end else begin
         weight_in = wide_in[WEIGHT_W-1:0];
      end
   end

   // sample ring: read every cycle at the write pointer into a register, written back in ST_SAMPLE
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[wr_idx_ff] <= raw_ff;
      end
      rd_data_ff <= ring[wr_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         prec_ff      <= PREC_RESET;
         wr_idx_ff    <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         ref_ff       <= '0;
         tared_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN:      gain_ff <= csr_wdata[GAIN_W-1:0];
               CSR_PRECISION: prec_ff <= csr_wdata[PREC_W-1:0];
               default: ;
            endcase
         end
         // in ST_DONE the output register is reloaded below instead
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  raw_ff <= raw_in;
                  case (req_type)
                     REQ_SAMPLE: state_ff <= ST_SAMPLE;
                     REQ_TARE: begin
                        ref_ff   <= sum_ff;
                        tared_ff <= 1'b1;
                     end
                     REQ_READ: begin
                        auto_ff <= !tared_ff;
                        if (!tared_ff) begin
                           ref_ff   <= sum_ff;
                           tared_ff <= 1'b1;
                        end
                        state_ff <= ST_DIFF;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SAMPLE: begin
               sum_ff <= sum_ff - SUM_W'(old_in) + SUM_W'(raw_ff);
               if (wr_idx_ff == TAPS_W'(TAPS - 1)) begin
                  wr_idx_ff  <= '0;
                  wrapped_ff <= 1'b1;
               end else begin
                  wr_idx_ff <= wr_idx_ff + TAPS_W'(1);
               end
               state_ff <= ST_IDLE;
            end
            ST_DIFF: begin
               neg_ff     <= diff_in[SUM_W];
               absdiff_ff <= diff_in[SUM_W] ? SUM_W'(-diff_in) : diff_in[SUM_W-1:0];
               state_ff   <= ST_MUL;
            end
            ST_MUL: begin
               mag_ff    <= prod_in[PROD_W-1:SHIFT];
               mag_sh_ff <= prod_in[PROD_W-1:SHIFT];
               rem_ff    <= '0;
               cnt_ff    <= CNT_W'(MAG_W - 1);
               state_ff  <= (prec_ff == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
               rem_ff    <= rem_in;
               mag_sh_ff <= {mag_sh_ff[MAG_W-2:0], 1'b0};
               cnt_ff    <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  weight_ff    <= weight_in;
                  auto_out_ff  <= auto_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighing front end: a queue-fed driver, a
// monitor that compares each weight against an in-bench moving-average and
// tare predictor, and register phases run with different idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import lcats_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 40;

   typedef struct {
      req_code_type       kind;
      logic [BYTE_W-1:0]  hi;
      logic [BYTE_W-1:0]  lo;
   } scale_request_t;

   typedef struct {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       auto_tared;
   } weight_reading_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [REQ_W-1:0]             req_type = REQ_SAMPLE;
   logic [BYTE_W-1:0]            req_adc_high_byte = '0;
   logic [BYTE_W-1:0]            req_adc_low_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [WEIGHT_W-1:0]   rsp_weight;
   logic                         rsp_auto_tared;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = CSR_GAIN;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // predictor state
   logic [RAW_W-1:0]   ring_model [TAPS];
   logic [TAPS_W-1:0]  slot_model;
   logic [SUM_W-1:0]   sum_model;
   logic [SUM_W-1:0]   tare_model;
   logic               tared_model;
   logic [GAIN_W-1:0]  gain_model;
   logic [PREC_W-1:0]  prec_model;

   scale_request_t     scale_requests[$];
   weight_reading_t    expected_weights[$];
   scale_request_t     cur_request;
   int                 requests_in_flight = 0;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 burst_left = 0;
   int                 burst_level = 0;
   int                 burst_spread = 0;

   load_cell_averaging_tare_scale DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_adc_high_byte (req_adc_high_byte),
      .req_adc_low_byte  (req_adc_low_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_weight        (rsp_weight),
      .rsp_auto_tared    (rsp_auto_tared),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [WEIGHT_W-1:0] scaled_weight();
      logic signed [SUM_W:0]  diff;
      logic [SUM_W-1:0]       mag_in;
      logic [PROD_W-1:0]      prod;
      logic                   neg;
      int                     mag;
      int                     rem;
      int                     w;
      diff = $signed({1'b0, sum_model}) - $signed({1'b0, tare_model});
      neg = diff < 0;
      mag_in = SUM_W'(neg ? -diff : diff);
      prod = PROD_W'(mag_in) * PROD_W'(gain_model);
      mag = int'(prod >> SHIFT);
      if (prec_model != 0) begin
         rem = mag % int'(prec_model);
         if (neg) mag = mag - rem;
         else if (rem != 0) mag = mag + int'(prec_model) - rem;
      end
      w = neg ? -mag : mag;
      if (w > 32767) w = 32767;
      if (w < -32768) w = -32768;
      return WEIGHT_W'(w);
   endfunction

   function automatic void update_scale(scale_request_t r);
      logic [RAW_W-1:0] raw;
      weight_reading_t  res;
      case (r.kind)
         REQ_SAMPLE: begin
            raw = {r.hi[4:0], r.lo[7:1]};
            sum_model = sum_model - ring_model[slot_model] + raw;
            ring_model[slot_model] = raw;
            slot_model = slot_model + 1'b1;
         end
         REQ_TARE: begin
            tare_model = sum_model;
            tared_model = 1'b1;
         end
         REQ_READ: begin
            res.auto_tared = !tared_model;
            if (!tared_model) begin
               tare_model = sum_model;
               tared_model = 1'b1;
            end
            res.weight = scaled_weight();
            expected_weights.push_back(res);
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_scale(cur_request);
            requests_in_flight--;
         end
         if (!req_valid || !req_stall) begin
            if (scale_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_request = scale_requests.pop_front();
               req_valid <= 1'b1;
               req_type <= cur_request.kind;
               req_adc_high_byte <= cur_request.hi;
               req_adc_low_byte <= cur_request.lo;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      weight_reading_t exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_weights.size() == 0) begin
            $display("%0t: unexpected item weight=%0d auto_tared=%0b", $time,
                     rsp_weight, rsp_auto_tared);
            mismatch_count++;
         end else begin
            exp_r = expected_weights.pop_front();
            if (rsp_weight !== exp_r.weight) begin
               $display("%0t: weight expected %0d actual %0d", $time,
                        exp_r.weight, rsp_weight);
               mismatch_count++;
            end
            if (rsp_auto_tared !== exp_r.auto_tared) begin
               $display("%0t: auto_tared expected %0b actual %0b", $time,
                        exp_r.auto_tared, rsp_auto_tared);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic push_request(req_code_type kind, logic [BYTE_W-1:0] hi,
                               logic [BYTE_W-1:0] lo);
      scale_request_t r;
      r.kind = kind;
      r.hi = hi;
      r.lo = lo;
      requests_in_flight++;
      scale_requests.push_back(r);
   endtask

   // bursts of samples around a level, with reads, tares and no-op codes mixed in
   task automatic queue_random(int count);
      int             done;
      int             roll;
      int             raw;
      req_code_type   kind;
      done = 0;
      while (done < count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(200, 1);
            roll = $urandom_range(99);
            burst_level = roll < 10 ? 0 : roll < 20 ? 4095 : $urandom_range(4095);
            case ($urandom_range(3))
               0: burst_spread = 0;
               1: burst_spread = 15;
               2: burst_spread = 300;
               default: burst_spread = 4095;
            endcase
         end
         burst_left--;
         raw = burst_level + $urandom_range(2 * burst_spread) - burst_spread;
         if (raw < 0) raw = 0;
         if (raw > 4095) raw = 4095;
         roll = $urandom_range(99);
         kind = roll < 78 ? REQ_SAMPLE : roll < 94 ? REQ_READ : roll < 98 ? REQ_TARE :
                REQ_NONE;
         push_request(kind, {3'($urandom), 5'(raw >> 7)}, {7'(raw), 1'($urandom)});
         if (kind != REQ_NONE) done++;
      end
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GAIN:      gain_model = data[GAIN_W-1:0];
         CSR_PRECISION: prec_model = data[PREC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (requests_in_flight != 0 || expected_weights.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < TAPS; i++) ring_model[i] = '0;
      slot_model = '0;
      sum_model = '0;
      tare_model = '0;
      tared_model = 1'b0;
      gain_model = GAIN_RESET;
      prec_model = PREC_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset values, first read tares automatically
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_READ, 8'hFF, 8'hFF);
      push_request(REQ_SAMPLE, 8'hFF, 8'hFF);
      push_request(REQ_SAMPLE, 8'hE0, 8'h01);
      push_request(REQ_SAMPLE, 8'h1F, 8'hFE);
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_NONE, 8'hA5, 8'h5A);
      push_request(REQ_TARE, 8'h00, 8'h00);
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_SAMPLE, 8'h10, 8'h00);
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_SAMPLE, 8'h00, 8'h00);
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_TARE, 8'hFF, 8'hFF);
      push_request(REQ_READ, 8'h00, 8'h00);
      for (int i = 0; i < 4; i++) push_request(REQ_SAMPLE, 8'h1F, 8'hFF);
      push_request(REQ_READ, 8'h00, 8'h00);
      push_request(REQ_SAMPLE, 8'h00, 8'h02);
      push_request(REQ_READ, 8'h00, 8'h00);
      wait_drained();

      write_register(CSR_GAIN, 32'd262143);
      write_register(CSR_PRECISION, 32'd0);
      queue_random(200);
      wait_drained();

      write_register(CSR_GAIN, 32'd0);
      write_register(CSR_PRECISION, 32'd255);
      send_idle_pct = 57;
      queue_random(100);
      wait_drained();

      // sender holds off mid-phase until all weights are back
      write_register(CSR_GAIN, {14'($urandom), 18'($urandom)});
      write_register(CSR_PRECISION, {24'($urandom), 8'd1});
      send_idle_pct = 0;
      recv_stall_pct = 57;
      queue_random(100);
      wait_drained();
      queue_random(100);
      wait_drained();

      write_register(CSR_GAIN, 32'd262143);
      write_register(CSR_PRECISION, 32'd255);
      send_idle_pct = 20;
      recv_stall_pct = 20;
      queue_random(200);
      wait_drained();

      write_register(CSR_SPARE2, $urandom);
      write_register(CSR_SPARE3, $urandom);
      write_register(CSR_GAIN, 32'(GAIN_RESET));
      write_register(CSR_PRECISION, 32'($urandom_range(254, 2)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random(250);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
